// File: rtl/cse_pkg.sv
// shared types and constants for the cell state-of-charge estimator
// no dependencies; imported by every module of the block
package cse_pkg;

  typedef struct packed {
    logic [4:0]  cell_number;
    logic [12:0] cell_voltage_mv;
    logic [15:0] cell_resistance;
    logic [15:0] discharge_current_ma;
    logic [15:0] charge_current_ma;
  } cse_in_t;

  typedef struct packed {
    logic [4:0]  cell_number_out;
    logic [15:0] open_circuit_mv;
    logic [6:0]  soc_percent;
  } cse_out_t;

  // intermediate item between compensation and curve lookup
  typedef struct packed {
    logic [4:0]  cell_number;
    logic [15:0] open_circuit_mv;
  } cse_ocv_t;

  typedef logic [3:0] cse_seg_t;

  // ir drop divisor and its reciprocal floor(2^32 / 10000)
  localparam logic [13:0] CSE_DIV   = 14'd10000;
  localparam logic [18:0] CSE_RECIP = 19'd429496;

  // curve quotient by 1000: ceil(2^25 / 1000), exact for products below 59000
  localparam logic [15:0] CSE_SOC_RECIP = 16'd33555;
  localparam int          CSE_SOC_SHIFT = 25;

  localparam logic [6:0] CSE_SOC_MAX = 7'd100;
  localparam logic [8:0] CSE_X_MAX   = 9'd511;

  // segment zero is the region below the first knee, giving zero
  localparam int       CSE_SEGS     = 10;
  localparam cse_seg_t CSE_SEG_HALF = 4'd1;

  localparam logic [15:0] CSE_SEG_LO [CSE_SEGS] = '{
    16'd0,    16'd3220, 16'd3540, 16'd3680, 16'd3800,
    16'd3880, 16'd3980, 16'd4020, 16'd4060, 16'd4080
  };

  // first segment uses 22/1000 in place of 11/500, then rounds by halving
  localparam logic [8:0] CSE_SEG_SLOPE [CSE_SEGS] = '{
    9'd0,   9'd22,  9'd29, 9'd258, 9'd275,
    9'd110, 9'd225, 9'd75, 9'd300, 9'd83
  };

  localparam logic [6:0] CSE_SEG_BASE [CSE_SEGS] = '{
    7'd0,  7'd0,  7'd4,  7'd8,  7'd39,
    7'd61, 7'd72, 7'd81, 7'd84, 7'd90
  };

endpackage

// File: rtl/cse_comp.sv
// ir-compensated open-circuit voltage, six register stages
// depends on cse_pkg
module cse_comp (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cse_pkg::cse_in_t  in_item,
  output logic              out_valid,
  output cse_pkg::cse_ocv_t out_ocv
);
  import cse_pkg::*;

  logic [5:0]  vld;

  logic [16:0] diff;
  logic [4:0]  s1_cell;
  logic [12:0] s1_volt;
  logic [15:0] s1_res;
  logic        s1_neg;
  logic [15:0] s1_mag;

  logic [4:0]  s2_cell;
  logic [12:0] s2_volt;
  logic        s2_neg;
  logic [31:0] s2_prod;

  logic [50:0] recip_full;
  logic [4:0]  s3_cell;
  logic [12:0] s3_volt;
  logic        s3_neg;
  logic [31:0] s3_prod;
  logic [18:0] s3_qe;

  logic [32:0] qx_full;
  logic [4:0]  s4_cell;
  logic [12:0] s4_volt;
  logic        s4_neg;
  logic [31:0] s4_prod;
  logic [18:0] s4_qe;
  logic [31:0] s4_qx;

  logic [31:0] rem;
  logic [4:0]  s5_cell;
  logic [12:0] s5_volt;
  logic        s5_neg;
  logic [18:0] s5_q;

  logic [19:0] sum;
  logic [15:0] ocv_next;

  assign diff       = {1'b0, in_item.discharge_current_ma} - {1'b0, in_item.charge_current_ma};
  assign recip_full = 51'(s2_prod) * 51'(CSE_RECIP);
  assign qx_full    = 33'(s3_qe) * 33'(CSE_DIV);
  assign rem        = s4_prod - s4_qx;
  assign sum        = 20'(s5_volt) + 20'(s5_q);

  // sign and magnitude: the quotient truncates toward zero
  always_comb begin
    if (s5_neg) begin
      if (s5_q > 19'(s5_volt)) begin
        ocv_next = 16'd0;
      end else begin
        ocv_next = 16'(19'(s5_volt) - s5_q);
      end
    end else begin
      if (sum > 20'd65535) begin
        ocv_next = 16'hFFFF;
      end else begin
        ocv_next = sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 6'd0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_cell <= in_item.cell_number;
    s1_volt <= in_item.cell_voltage_mv;
    s1_res  <= in_item.cell_resistance;
    s1_neg  <= diff[16];
    s1_mag  <= diff[16] ? 16'(-diff) : diff[15:0];

    s2_cell <= s1_cell;
    s2_volt <= s1_volt;
    s2_neg  <= s1_neg;
    s2_prod <= 32'(s1_mag) * 32'(s1_res);

    // estimate is the true quotient or one below it
    s3_cell <= s2_cell;
    s3_volt <= s2_volt;
    s3_neg  <= s2_neg;
    s3_prod <= s2_prod;
    s3_qe   <= recip_full[50:32];

    s4_cell <= s3_cell;
    s4_volt <= s3_volt;
    s4_neg  <= s3_neg;
    s4_prod <= s3_prod;
    s4_qe   <= s3_qe;
    s4_qx   <= qx_full[31:0];

    s5_cell <= s4_cell;
    s5_volt <= s4_volt;
    s5_neg  <= s4_neg;
    s5_q    <= s4_qe + 19'(rem >= 32'(CSE_DIV));

    out_ocv.cell_number     <= s5_cell;
    out_ocv.open_circuit_mv <= ocv_next;
  end

  assign out_valid = vld[5];

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> rem < 32'd20000)
    else $error("reciprocal remainder out of range");

  a_neg_clamp: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && s5_neg && (s5_q > 19'(s5_volt))) |=> out_ocv.open_circuit_mv == 16'd0)
    else $error("negative estimate not clamped to zero");

  a_pos_ge: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !s5_neg) |=> out_ocv.open_circuit_mv >= 16'($past(s5_volt)))
    else $error("discharge compensation lowered the voltage");
`endif

endmodule

// File: rtl/cse_curve.sv
// piecewise-linear voltage to state-of-charge mapping, four register stages
// depends on cse_pkg
module cse_curve (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cse_pkg::cse_ocv_t in_ocv,
  output logic              out_valid,
  output cse_pkg::cse_out_t out_res
);
  import cse_pkg::*;

  logic [2:0]  vld;
  logic        done_reg;

  cse_seg_t    seg;
  logic [15:0] off;
  logic [4:0]  s1_cell;
  logic [15:0] s1_ocv;
  logic [8:0]  s1_x;
  logic [8:0]  s1_slope;
  logic [6:0]  s1_base;
  logic        s1_half;

  logic [4:0]  s2_cell;
  logic [15:0] s2_ocv;
  logic [17:0] s2_y;
  logic [6:0]  s2_base;
  logic        s2_half;

  logic [4:0]  s3_cell;
  logic [15:0] s3_ocv;
  logic [33:0] s3_pm;
  logic [6:0]  s3_base;
  logic        s3_half;

  logic [8:0]  q;
  logic [8:0]  scaled;
  logic [9:0]  soc_sum;
  logic [6:0]  soc_next;

  // knees ascend, so the last one passed names the segment
  always_comb begin
    seg = '0;
    for (int i = 1; i < CSE_SEGS; i++) begin
      if (in_ocv.open_circuit_mv >= CSE_SEG_LO[i]) begin
        seg = cse_seg_t'(i);
      end
    end
  end

  assign off = in_ocv.open_circuit_mv - CSE_SEG_LO[seg];

  assign q       = s3_pm[CSE_SOC_SHIFT +: 9];
  assign scaled  = s3_half ? 9'((10'(q) + 10'd1) >> 1) : q;
  assign soc_sum = 10'(s3_base) + 10'(scaled);
  assign soc_next = (soc_sum > 10'(CSE_SOC_MAX)) ? CSE_SOC_MAX : soc_sum[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= 3'd0;
      done_reg <= 1'b0;
    end else begin
      vld      <= {vld[1:0], in_valid};
      done_reg <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    // long top segment saturates well before the offset limit
    s1_cell  <= in_ocv.cell_number;
    s1_ocv   <= in_ocv.open_circuit_mv;
    s1_x     <= (off > 16'(CSE_X_MAX)) ? CSE_X_MAX : off[8:0];
    s1_slope <= CSE_SEG_SLOPE[seg];
    s1_base  <= CSE_SEG_BASE[seg];
    s1_half  <= (seg == CSE_SEG_HALF);

    s2_cell <= s1_cell;
    s2_ocv  <= s1_ocv;
    s2_y    <= 18'(s1_x) * 18'(s1_slope);
    s2_base <= s1_base;
    s2_half <= s1_half;

    s3_cell <= s2_cell;
    s3_ocv  <= s2_ocv;
    s3_pm   <= 34'(s2_y) * 34'(CSE_SOC_RECIP);
    s3_base <= s2_base;
    s3_half <= s2_half;

    out_res.cell_number_out <= s3_cell;
    out_res.open_circuit_mv <= s3_ocv;
    out_res.soc_percent     <= soc_next;
  end

  assign out_valid = done_reg;

`ifndef ASSERT_OFF
  a_soc_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.soc_percent <= CSE_SOC_MAX)
    else $error("state of charge above full");

  a_half_span: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && s1_half) |-> s1_x < 9'd320)
    else $error("first segment offset beyond its span");

  a_below_knee: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && (s3_ocv < CSE_SEG_LO[1])) |=> out_res.soc_percent == 7'd0)
    else $error("nonzero charge below the first knee");
`endif

endmodule

// File: rtl/cell_soc_estimator.sv
// top level of the cell state-of-charge estimator
// depends on cse_pkg, cse_comp and cse_curve
//
// usage:
//   input channel: drive item and raise start; the transfer happens at a
//   rising edge with start high and busy low. busy is always low, so one
//   cell sample can be taken every cycle.
//   result channel: done is high in each cycle that carries a valid result;
//   the transfer happens at the edge that ends each such cycle. results leave
//   in the order the samples arrived, one per sample.
//   pipeline: six stages form the compensated voltage (current difference,
//   16x16 ir product, reciprocal multiply by 1/10000, back-multiply,
//   correction, add and clamp); four stages map it through the curve
//   (segment select, slope multiply, reciprocal multiply by 1/1000, offset
//   and saturate).
//   throughput: one item per cycle, sustained.
//   reset: synchronous rst clears every stage valid bit; items in flight
//   are dropped and no done is raised until new samples arrive.
//   the receiver cannot stall, so no result is ever held back.
module cell_soc_estimator (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cse_pkg::cse_in_t item,
  output logic             done,
  output cse_pkg::cse_out_t result
);
  import cse_pkg::*;

  logic     ocv_valid;
  cse_ocv_t ocv;

  assign busy = 1'b0;

  cse_comp u_comp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_item   (item),
    .out_valid (ocv_valid),
    .out_ocv   (ocv)
  );

  cse_curve u_curve (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ocv_valid),
    .in_ocv    (ocv),
    .out_valid (done),
    .out_res   (result)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##10 done)
    else $error("result missing ten cycles after input transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 10))
    else $error("result without matching input transfer");

  a_zero_ocv: assert property (@(posedge clk) disable iff (rst)
    (done && (result.open_circuit_mv == 16'd0)) |-> result.soc_percent == 7'd0)
    else $error("charge reported for zero voltage");
`endif

endmodule

// File: tb/sv/cell_soc_estimator_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the cell state-of-charge estimator
// depends on cse_pkg and cell_soc_estimator; no files or arguments needed
module cell_soc_estimator_test;
  import cse_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  cse_in_t  item;
  logic     done;
  cse_out_t result;

  cse_out_t cell_results_due[$];
  int       mismatches;
  int       samples_sent;
  int       results_checked;
  int       clamped_low;
  int       clamped_high;
  int       full_charge;
  int       burst_left;

  cell_soc_estimator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // piecewise-linear ocv to state-of-charge curve, saturating at full
  function automatic logic [6:0] soc_for_ocv(input logic [15:0] ocv);
    int unsigned e;
    int unsigned s;
    e = ocv;
    if (e < 3220)
      s = 0;
    else if (e < 3540)
      s = (1 + ((e - 3220) * 11) / 500) / 2;
    else if (e < 3680)
      s = 4 + ((e - 3540) * 29) / 1000;
    else if (e < 3800)
      s = 8 + ((e - 3680) * 258) / 1000;
    else if (e < 3880)
      s = 39 + ((e - 3800) * 275) / 1000;
    else if (e < 3980)
      s = 61 + ((e - 3880) * 110) / 1000;
    else if (e < 4020)
      s = 72 + ((e - 3980) * 225) / 1000;
    else if (e < 4060)
      s = 81 + ((e - 4020) * 75) / 1000;
    else if (e < 4080)
      s = 84 + ((e - 4060) * 300) / 1000;
    else
      s = 90 + ((e - 4080) * 83) / 1000;
    if (s > 100)
      s = 100;
    return 7'(s);
  endfunction

  // ir-compensated open-circuit voltage, clamped, then curve lookup
  function automatic cse_out_t estimate_cell(input cse_in_t x);
    longint   ir_drop;
    longint   est;
    cse_out_t r;
    ir_drop = (longint'(x.discharge_current_ma) - longint'(x.charge_current_ma))
              * longint'(x.cell_resistance);
    // signed division truncates toward zero, as required
    est = longint'(x.cell_voltage_mv) + ir_drop / 10000;
    r.cell_number_out = x.cell_number;
    if (est < 0)
      r.open_circuit_mv = 16'd0;
    else if (est > 65535)
      r.open_circuit_mv = 16'hffff;
    else
      r.open_circuit_mv = 16'(est);
    r.soc_percent = soc_for_ocv(r.open_circuit_mv);
    return r;
  endfunction

  function automatic cse_in_t cell_sample(input logic [4:0] cell_no, input logic [12:0] mv,
                                          input logic [15:0] res, input logic [15:0] dis,
                                          input logic [15:0] chg);
    cse_in_t x;
    x.cell_number          = cell_no;
    x.cell_voltage_mv      = mv;
    x.cell_resistance      = res;
    x.discharge_current_ma = dis;
    x.charge_current_ma    = chg;
    return x;
  endfunction

  function automatic cse_in_t random_cell_sample();
    cse_in_t x;
    x.cell_number = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 18));
    x.cell_voltage_mv      = 13'($urandom);
    x.cell_resistance      = 16'($urandom);
    x.discharge_current_ma = 16'($urandom);
    x.charge_current_ma    = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        // realistic cells: voltage near the curve, modest ir drop
        x.cell_voltage_mv      = 13'($urandom_range(3100, 4400));
        x.cell_resistance      = 16'($urandom_range(0, 500));
        x.discharge_current_ma = 16'($urandom_range(0, 20000));
        x.charge_current_ma    = 16'($urandom_range(0, 20000));
      end
      7: x.discharge_current_ma = 16'($urandom_range(0, 1000));
      8: x.charge_current_ma = 16'($urandom_range(0, 1000));
      9: x.charge_current_ma = x.discharge_current_ma;
      default: ;
    endcase
    return x;
  endfunction

  // drive one sample and hold it until the transfer
  task automatic send_cell(input cse_in_t x);
    cse_out_t r;
    @(negedge clk);
    start = 1'b1;
    item  = x;
    do
      @(posedge clk);
    while (busy);
    r = estimate_cell(x);
    cell_results_due.push_back(r);
    samples_sent++;
    if (r.open_circuit_mv == 16'd0 && x.cell_voltage_mv != 13'd0)
      clamped_low++;
    if (r.open_circuit_mv == 16'hffff)
      clamped_high++;
    if (r.soc_percent == 7'd100)
      full_charge++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      item  = random_cell_sample();
    end
  endtask

  // bursts of random length, sometimes with no gaps at all
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0)
        idle_cycles($urandom_range(1, 9));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (cell_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic test_curve_knees();
    logic [12:0] knee_mv[$];
    knee_mv = '{13'd3219, 13'd3220, 13'd3539, 13'd3540, 13'd3680, 13'd3799, 13'd3800,
                13'd3880, 13'd3980, 13'd4020, 13'd4060, 13'd4080, 13'd4201};
    foreach (knee_mv[i])
      send_cell(cell_sample(5'($urandom_range(1, 18)), knee_mv[i], 16'd0, 16'd0, 16'd0));
  endtask

  task automatic test_range_extremes();
    send_cell(cell_sample(5'd1, 13'd0, 16'd0, 16'd0, 16'd0));
    send_cell(cell_sample(5'd18, 13'h1fff, 16'hffff, 16'hffff, 16'hffff));
    // ir term far above and far below range
    send_cell(cell_sample(5'd0, 13'h1fff, 16'hffff, 16'hffff, 16'd0));
    send_cell(cell_sample(5'd31, 13'd0, 16'hffff, 16'd0, 16'hffff));
    // partial quotients must truncate toward zero on both sides
    send_cell(cell_sample(5'd19, 13'd4000, 16'd9999, 16'd0, 16'd1));
    send_cell(cell_sample(5'd2, 13'd4000, 16'd9999, 16'd1, 16'd0));
    send_cell(cell_sample(5'd17, 13'd3300, 16'd3, 16'd0, 16'd65535));
    send_cell(cell_sample(5'd9, 13'h1555, 16'haaaa, 16'h5555, 16'haaaa));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) begin
      pace_sender();
      send_cell(random_cell_sample());
    end
  endtask

  // result checker: each cycle with done high carries one result; done cannot be held off
  always @(posedge clk) begin
    cse_out_t want;
    if (!rst && done) begin
      if (cell_results_due.size() == 0) begin
        $display("%0t: unexpected result cell %0d ocv %0d soc %0d", $time,
                 result.cell_number_out, result.open_circuit_mv, result.soc_percent);
        mismatches++;
      end else begin
        want = cell_results_due.pop_front();
        results_checked++;
        if (result.cell_number_out !== want.cell_number_out) begin
          $display("%0t: cell_number_out expected %0d actual %0d", $time,
                   want.cell_number_out, result.cell_number_out);
          mismatches++;
        end
        if (result.open_circuit_mv !== want.open_circuit_mv) begin
          $display("%0t: open_circuit_mv expected %0d actual %0d", $time,
                   want.open_circuit_mv, result.open_circuit_mv);
          mismatches++;
        end
        if (result.soc_percent !== want.soc_percent) begin
          $display("%0t: soc_percent expected %0d actual %0d", $time,
                   want.soc_percent, result.soc_percent);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    item            = '0;
    mismatches      = 0;
    samples_sent    = 0;
    results_checked = 0;
    clamped_low     = 0;
    clamped_high    = 0;
    full_charge     = 0;
    burst_left      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_curve_knees();
    test_range_extremes();
    test_random_traffic(700);
    // let the pipeline empty completely before carrying on
    wait_drained();
    test_random_traffic(750);

    wait_drained();
    repeat (16) @(posedge clk);
    if (cell_results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, cell_results_due.size());
      mismatches++;
    end
    $display("%0d cell samples sent, %0d results checked", samples_sent, results_checked);
    $display("ocv clamped low %0d, clamped high %0d; %0d at full charge",
             clamped_low, clamped_high, full_charge);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
